### design/rrb_pkg.sv
// Package for the RTP reorder buffer: status codes, engine states, config indices, shared structs.
// No dependencies.
package rrb_pkg;

  localparam int SeqBits    = 16;
  localparam int LenBits    = 11;
  localparam int HandleBits = 16;
  localparam int TimeBits   = 32;
  localparam int SkipBits   = 7;
  localparam int ResultCap  = 32;
  localparam int ResIdxBits = 5;
  localparam int ResCntBits = 6;
  localparam int EntryBits  = HandleBits + LenBits + 1;

  typedef enum logic [2:0] {
    ST_INORDER  = 3'd0,
    ST_CACHED   = 3'd1,
    ST_STALE    = 3'd2,
    ST_REANCHOR = 3'd3,
    ST_INVALID  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLASSIFY,
    S_DRAIN_RD,
    S_DRAIN_WR,
    S_SKIP,
    S_FINISH,
    S_EMIT
  } eng_state_t;

  typedef enum logic [1:0] {
    CFG_GAP_TIMEOUT      = 2'd0,
    CFG_FALLBACK_TIMEOUT = 2'd1
  } cfg_reg_t;

  // classified item handed from front to engine
  typedef struct packed {
    logic [SeqBits-1:0]    seq_num;
    logic [LenBits-1:0]    pkt_len;
    logic [HandleBits-1:0] pkt_handle;
    logic                  gop_start;
    logic [TimeBits-1:0]   now_time;
    logic                  invalid;
  } cmd_t;

  typedef struct packed {
    logic                  has_packet;
    logic [HandleBits-1:0] handle;
    logic [LenBits-1:0]    len;
    logic                  gop;
  } res_t;

endpackage

### design/rrb_if.sv
// Channel interfaces: packet input, result output and configuration writes.
// No dependencies.
interface rrb_pkt_if;
  logic        valid;
  logic        ready;
  logic [15:0] seq_num;
  logic [10:0] pkt_len;
  logic [15:0] pkt_handle;
  logic        gop_start;
  logic [31:0] now_time;
  modport source (output valid, seq_num, pkt_len, pkt_handle, gop_start, now_time,
                  input ready);
  modport sink (input valid, seq_num, pkt_len, pkt_handle, gop_start, now_time,
                output ready);
endinterface

interface rrb_res_if;
  logic        valid;
  logic        ready;
  logic        has_packet;
  logic [15:0] out_handle;
  logic [10:0] out_len;
  logic        out_gop_start;
  logic [2:0]  step_status;
  logic [6:0]  skipped_count;
  logic        last;
  modport source (output valid, has_packet, out_handle, out_len, out_gop_start,
                  step_status, skipped_count, last, input ready);
  modport sink (input valid, has_packet, out_handle, out_len, out_gop_start,
                step_status, skipped_count, last, output ready);
endinterface

interface rrb_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### design/rtp_reorder_buffer_top.sv
// Top level of the RTP reorder buffer: configuration registers, front end, engine.
// Depends on rrb_pkg, rrb_if, rrb_front, rrb_engine.
//
//  channel  | role | transfer when
//  pkt_in   | sink | pkt_in.valid && pkt_in.ready
//  res_out  | src  | res_out.valid && res_out.ready
//  cfg      | sink | cfg.valid (ready always high)
//
// One item at a time in the engine: it is taken from the queue (IDLE), classified
// (CLASSIFY), then each drained packet takes a read state and a write state (the slot RAM
// read is registered), and a final read finds the gap; each skipped number takes a SKIP
// state, then SKIP returns to the drain read; FINISH closes the item and EMIT shows one
// result per transfer on the output. Output stalls hold the engine; a two-deep input
// queue keeps accepting while results wait.
// Synchronous reset clears the slot valid bits at once.
module rtp_reorder_buffer_top #(
  parameter int SLOT_COUNT       = 32,
  parameter int MAX_PACKET_BYTES = 1500,
  parameter int HANDLE_BITS      = 16
) (
  input logic       clk,
  input logic       rst,
  rrb_pkt_if.sink   pkt_in,
  rrb_res_if.source res_out,
  rrb_cfg_if.sink   cfg
);
  logic [31:0]   gap_timeout, fallback_timeout, timeout;
  rrb_pkg::cmd_t cmd;
  logic          cmd_valid, cmd_ready;

  assign cfg.ready = 1'b1;
  assign timeout   = (gap_timeout != '0) ? gap_timeout : fallback_timeout;

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_timeout      <= '0;
      fallback_timeout <= 32'd100;
    end else if (cfg.valid) begin
      case (cfg.index)
        rrb_pkg::CFG_GAP_TIMEOUT:      gap_timeout <= cfg.data;
        rrb_pkg::CFG_FALLBACK_TIMEOUT: fallback_timeout <= cfg.data;
        default: ;
      endcase
    end
  end

  rrb_front #(.MAX_PACKET_BYTES(MAX_PACKET_BYTES), .HANDLE_BITS(HANDLE_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .pkt_in    (pkt_in),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready)
  );

  rrb_engine #(.SLOT_COUNT(SLOT_COUNT)) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .timeout   (timeout),
    .res_out   (res_out)
  );
endmodule

### design/rrb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rrb_ram #(
  parameter int WIDTH = 28,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### design/rrb_front.sv
// Front end: checks packet length, masks the handle and queues items (two deep).
// Depends on rrb_pkg and rrb_if.
module rrb_front #(
  parameter int MAX_PACKET_BYTES = 1500,
  parameter int HANDLE_BITS      = 16
) (
  input  logic          clk,
  input  logic          rst,
  rrb_pkt_if.sink       pkt_in,
  output rrb_pkg::cmd_t cmd,
  output logic          cmd_valid,
  input  logic          cmd_ready
);
  localparam logic [15:0] HandleMask =
    (HANDLE_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << HANDLE_BITS) - 32'd1);

  rrb_pkg::cmd_t q [2];
  logic          wr_ptr, rd_ptr;
  logic [1:0]    count;
  rrb_pkg::cmd_t in_cmd;
  logic          push, pop;

  always_comb begin
    in_cmd.seq_num    = pkt_in.seq_num;
    in_cmd.pkt_len    = pkt_in.pkt_len;
    in_cmd.pkt_handle = pkt_in.pkt_handle & HandleMask;
    in_cmd.gop_start  = pkt_in.gop_start;
    in_cmd.now_time   = pkt_in.now_time;
    in_cmd.invalid    = (pkt_in.pkt_len == '0) ||
                        (pkt_in.pkt_len > 11'(MAX_PACKET_BYTES));
  end

  assign pkt_in.ready = (count != 2'd2);
  assign push         = pkt_in.valid && pkt_in.ready;
  assign cmd_valid    = (count != 2'd0);
  assign pop          = cmd_valid && cmd_ready;
  assign cmd          = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= in_cmd;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule

### design/rrb_engine.sv
// Back end: sequence tracking, slot store, drain and gap skip, result buffer.
// Depends on rrb_pkg, rrb_if and rrb_ram.
module rrb_engine #(
  parameter int SLOT_COUNT = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  rrb_pkg::cmd_t cmd,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  logic [31:0]   timeout,
  rrb_res_if.source     res_out
);
  localparam int SlotBits = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int PendBits = $clog2(SLOT_COUNT + 1);

  rrb_pkg::eng_state_t st, st_next;
  rrb_pkg::cmd_t       w;
  rrb_pkg::status_t    status;
  logic [15:0]         expected_seq;
  logic                anchored;
  logic [PendBits-1:0] pending;
  logic [31:0]         gap_start;
  logic [SLOT_COUNT-1:0] slot_valid;
  logic [6:0]          skipped;
  logic [PendBits-1:0] skip_cnt;
  logic                chk;
  logic [rrb_pkg::ResCntBits-1:0] n_res;
  logic [rrb_pkg::ResIdxBits-1:0] rd_idx;
  rrb_pkg::res_t       res_buf [rrb_pkg::ResultCap];

  logic [15:0]         exp_eff, seq_dist;
  logic [SlotBits-1:0] exp_slot, seq_slot;
  logic [31:0]         gap_eff;
  logic                ram_we;
  logic [rrb_pkg::EntryBits-1:0] ram_rdata, ram_wdata;
  rrb_pkg::res_t       ram_res, out_res;
  logic                out_last;

  assign exp_eff  = anchored ? expected_seq : w.seq_num;
  assign seq_dist = w.seq_num - exp_eff;
  assign exp_slot = expected_seq[SlotBits-1:0];
  assign seq_slot = w.seq_num[SlotBits-1:0];
  assign gap_eff  = (gap_start == '0) ? w.now_time : gap_start;
  assign ram_wdata = {w.gop_start, w.pkt_len, w.pkt_handle};
  assign ram_res  = '{has_packet: 1'b1, handle: ram_rdata[15:0],
                      len: ram_rdata[26:16], gop: ram_rdata[27]};
  assign ram_we   = (st == rrb_pkg::S_CLASSIFY) && !w.invalid && seq_dist != '0 &&
                    !seq_dist[15] && seq_dist < 16'(SLOT_COUNT);

  rrb_ram #(.WIDTH(rrb_pkg::EntryBits), .DEPTH(SLOT_COUNT)) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (seq_slot),
    .wdata (ram_wdata),
    .raddr (exp_slot),
    .rdata (ram_rdata)
  );

  assign out_res  = res_buf[rd_idx];
  assign out_last = (6'(rd_idx) + 6'd1 == n_res);

  always_comb begin
    cmd_ready             = (st == rrb_pkg::S_IDLE);
    res_out.valid         = (st == rrb_pkg::S_EMIT);
    res_out.has_packet    = out_res.has_packet;
    res_out.out_handle    = out_res.handle;
    res_out.out_len       = out_res.len;
    res_out.out_gop_start = out_res.gop;
    res_out.step_status   = status;
    res_out.skipped_count = skipped;
    res_out.last          = out_last;
  end

  always_comb begin
    st_next = st;
    case (st)
      rrb_pkg::S_IDLE:     if (cmd_valid) st_next = rrb_pkg::S_CLASSIFY;
      rrb_pkg::S_CLASSIFY: begin
        if (w.invalid) st_next = rrb_pkg::S_FINISH;
        else if (seq_dist == '0) st_next = rrb_pkg::S_DRAIN_RD;
        else if (!seq_dist[15] && seq_dist < 16'(SLOT_COUNT) &&
                 (w.now_time - gap_eff >= timeout)) st_next = rrb_pkg::S_SKIP;
        else st_next = rrb_pkg::S_FINISH;
      end
      rrb_pkg::S_DRAIN_RD: begin
        if (slot_valid[exp_slot]) st_next = rrb_pkg::S_DRAIN_WR;
        else if (chk && pending != '0 && (w.now_time - gap_start >= timeout))
          st_next = rrb_pkg::S_SKIP;
        else st_next = rrb_pkg::S_FINISH;
      end
      rrb_pkg::S_DRAIN_WR: st_next = rrb_pkg::S_DRAIN_RD;
      rrb_pkg::S_SKIP: begin
        if (slot_valid[exp_slot] || skip_cnt == PendBits'(SLOT_COUNT))
          st_next = rrb_pkg::S_DRAIN_RD;
      end
      rrb_pkg::S_FINISH:   st_next = rrb_pkg::S_EMIT;
      rrb_pkg::S_EMIT:     if (res_out.ready && out_last) st_next = rrb_pkg::S_IDLE;
      default:             st_next = rrb_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) st <= rrb_pkg::S_IDLE;
    else     st <= st_next;
  end

  always_ff @(posedge clk) begin
    if (st == rrb_pkg::S_IDLE && cmd_valid) w <= cmd;
    if (rst) begin
      expected_seq <= '0;
      anchored     <= 1'b0;
      pending      <= '0;
      gap_start    <= '0;
      slot_valid   <= '0;
      skipped      <= '0;
      skip_cnt     <= '0;
      chk          <= 1'b0;
      n_res        <= '0;
      rd_idx       <= '0;
      status       <= rrb_pkg::ST_INVALID;
    end else begin
      case (st)
        rrb_pkg::S_IDLE: begin
          n_res    <= '0;
          rd_idx   <= '0;
          skipped  <= '0;
          skip_cnt <= '0;
          chk      <= 1'b0;
        end
        rrb_pkg::S_CLASSIFY: begin
          if (w.invalid) begin
            status <= rrb_pkg::ST_INVALID;
          end else begin
            anchored <= 1'b1;
            if (seq_dist == '0) begin
              status       <= rrb_pkg::ST_INORDER;
              res_buf[0]   <= '{1'b1, w.pkt_handle, w.pkt_len, w.gop_start};
              n_res        <= 6'd1;
              expected_seq <= exp_eff + 16'd1;
              chk          <= 1'b1;
            end else if (!seq_dist[15] && seq_dist >= 16'(SLOT_COUNT)) begin
              // re-anchor: flush the store and restart on this packet
              status       <= rrb_pkg::ST_REANCHOR;
              slot_valid   <= '0;
              pending      <= '0;
              gap_start    <= '0;
              res_buf[0]   <= '{1'b1, w.pkt_handle, w.pkt_len, w.gop_start};
              n_res        <= 6'd1;
              expected_seq <= w.seq_num + 16'd1;
            end else if (!seq_dist[15]) begin
              status               <= rrb_pkg::ST_CACHED;
              slot_valid[seq_slot] <= 1'b1;
              if (!slot_valid[seq_slot]) pending <= pending + PendBits'(1);
              gap_start            <= gap_eff;
            end else begin
              status <= rrb_pkg::ST_STALE;
            end
          end
        end
        rrb_pkg::S_DRAIN_RD: begin
          if (!slot_valid[exp_slot]) begin
            if (pending == '0) gap_start <= '0;
            chk <= 1'b0;
          end
        end
        rrb_pkg::S_DRAIN_WR: begin
          if (n_res < 6'(rrb_pkg::ResultCap)) begin
            res_buf[n_res[rrb_pkg::ResIdxBits-1:0]] <= ram_res;
            n_res <= n_res + 6'd1;
          end
          slot_valid[exp_slot] <= 1'b0;
          if (pending != '0) pending <= pending - PendBits'(1);
          expected_seq <= expected_seq + 16'd1;
        end
        rrb_pkg::S_SKIP: begin
          chk <= 1'b0;
          if (!slot_valid[exp_slot] && skip_cnt != PendBits'(SLOT_COUNT)) begin
            expected_seq <= expected_seq + 16'd1;
            skipped      <= skipped + 7'd1;
            skip_cnt     <= skip_cnt + PendBits'(1);
          end
        end
        rrb_pkg::S_FINISH: begin
          // status-only result when nothing was emitted
          if (n_res == '0) begin
            res_buf[0] <= '0;
            n_res      <= 6'd1;
          end
        end
        rrb_pkg::S_EMIT: begin
          if (res_out.ready && !out_last) rd_idx <= rd_idx + rrb_pkg::ResIdxBits'(1);
        end
        default: ;
      endcase
    end
  end
endmodule

### design/rrb_checker.sv
// Port-level checks for the reorder buffer, bound to the top level.
// Depends on rrb_pkg and rtp_reorder_buffer_top.
module rrb_checker (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic        has_packet,
  input logic [15:0] out_handle,
  input logic [10:0] out_len,
  input logic        last,
  input logic [2:0]  step_status,
  input logic        cfg_ready
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  a_idle_after_rst: assert property (@(posedge clk) $past(rst) |-> !res_valid)
    else $error("result shown right after reset");

  a_status_only: assert property (@(posedge clk) disable iff (rst)
    res_valid && !has_packet |-> out_handle == '0 && out_len == '0 && last)
    else $error("status-only result carries data or is not last");

  a_invalid: assert property (@(posedge clk) disable iff (rst)
    res_valid && step_status == rrb_pkg::ST_INVALID |-> !has_packet)
    else $error("invalid item emitted a packet");

  a_cfg: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("configuration port not ready");
endmodule

bind rtp_reorder_buffer_top rrb_checker u_rrb_checker (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (res_out.valid),
  .res_ready   (res_out.ready),
  .has_packet  (res_out.has_packet),
  .out_handle  (res_out.out_handle),
  .out_len     (res_out.out_len),
  .last        (res_out.last),
  .step_status (res_out.step_status),
  .cfg_ready   (cfg.ready)
);

### tb/sv/rtp_reorder_buffer_top_test.sv
// Self-checking testbench for rtp_reorder_buffer_top: random and directed descriptors
// checked against an in-bench reorder predictor. Depends on rrb_pkg, rrb_if and the top.
module rtp_reorder_buffer_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Slots     = 32;
  localparam int MaxBytes  = 1500;
  localparam int CycleLimit = 2000000;

  typedef struct {
    logic [15:0] seq;
    logic [10:0] len;
    logic [15:0] handle;
    logic        gop;
    logic [31:0] now;
  } pkt_t;

  typedef struct {
    logic             has_packet;
    logic [15:0]      handle;
    logic [10:0]      len;
    logic             gop;
    rrb_pkg::status_t status;
    logic [6:0]       skipped;
    logic             last;
  } res_t;

  logic clk;
  logic rst;

  rrb_pkt_if pin ();
  rrb_res_if rout ();
  rrb_cfg_if cfgc ();

  rtp_reorder_buffer_top u_dut (
    .clk     (clk),
    .rst     (rst),
    .pkt_in  (pin),
    .res_out (rout),
    .cfg     (cfgc)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // reorder state mirrored by the predictor
  logic [31:0] gap_to;
  logic [31:0] fb_to;
  logic [15:0] exp_seq;
  bit          anchored;
  int          pend_n;
  logic [31:0] gap_t0;
  bit          slot_v [Slots];
  logic [15:0] slot_h [Slots];
  logic [10:0] slot_l [Slots];
  bit          slot_g [Slots];
  int          skip_n;
  res_t        batch [$];

  res_t        expected_q [$];
  pkt_t        pending_q [$];
  int          errors;
  bit          quiet;
  bit          hold_req;

  function automatic void push_pkt(logic [15:0] h, logic [10:0] l, bit g);
    res_t r;
    if (batch.size() >= rrb_pkg::ResultCap) return;
    r.has_packet = 1'b1;
    r.handle = h;
    r.len = l;
    r.gop = g;
    batch.push_back(r);
  endfunction

  function automatic void clear_stream();
    exp_seq = '0;
    anchored = 0;
    pend_n = 0;
    gap_t0 = '0;
    foreach (slot_v[i]) slot_v[i] = 0;
  endfunction

  function automatic void drain_slots();
    int s;
    for (int i = 0; i < Slots; i++) begin
      s = exp_seq % Slots;
      if (!slot_v[s]) break;
      push_pkt(slot_h[s], slot_l[s], slot_g[s]);
      slot_v[s] = 0;
      if (pend_n > 0) pend_n--;
      exp_seq = exp_seq + 16'd1;
    end
    if (pend_n == 0) gap_t0 = '0;
  endfunction

  function automatic void skip_missing();
    for (int i = 0; i < Slots; i++) begin
      if (slot_v[exp_seq % Slots]) break;
      exp_seq = exp_seq + 16'd1;
      skip_n++;
    end
    drain_slots();
  endfunction

  function automatic void predict_reorder(pkt_t p);
    rrb_pkg::status_t st;
    logic [31:0]      tmo;
    logic [15:0]      seq_gap;
    res_t             r;
    int               s;
    batch.delete();
    skip_n = 0;
    tmo = (gap_to != 0) ? gap_to : fb_to;
    if (p.len == 0 || p.len > MaxBytes) begin
      st = rrb_pkg::ST_INVALID;
    end else begin
      if (!anchored) begin
        exp_seq = p.seq;
        anchored = 1;
      end
      seq_gap = p.seq - exp_seq;
      if (seq_gap == 0) begin
        st = rrb_pkg::ST_INORDER;
        push_pkt(p.handle, p.len, p.gop);
        exp_seq = exp_seq + 16'd1;
        drain_slots();
        if (pend_n > 0 && p.now - gap_t0 >= tmo) skip_missing();
      end else if (seq_gap < 16'h8000) begin
        if (seq_gap >= Slots) begin
          st = rrb_pkg::ST_REANCHOR;
          clear_stream();
          anchored = 1;
          push_pkt(p.handle, p.len, p.gop);
          exp_seq = p.seq + 16'd1;
        end else begin
          st = rrb_pkg::ST_CACHED;
          s = p.seq % Slots;
          if (!slot_v[s]) pend_n++;
          slot_h[s] = p.handle;
          slot_l[s] = p.len;
          slot_g[s] = p.gop;
          slot_v[s] = 1;
          if (gap_t0 == 0) gap_t0 = p.now;
          if (p.now - gap_t0 >= tmo) skip_missing();
        end
      end else begin
        st = rrb_pkg::ST_STALE;
      end
    end
    if (batch.size() == 0) begin
      r.has_packet = 1'b0;
      r.handle = '0;
      r.len = '0;
      r.gop = 1'b0;
      batch.push_back(r);
    end
    foreach (batch[k]) begin
      r = batch[k];
      r.status = st;
      r.skipped = skip_n[6:0];
      r.last = (k == batch.size() - 1);
      expected_q.push_back(r);
    end
  endfunction

  // sender: one transfer per accepted descriptor
  bit   took;
  pkt_t cur;
  int   gap_left;

  always @(posedge clk) begin
    took = !rst && pin.valid && pin.ready;
    if (took) predict_reorder(cur);
  end

  always @(negedge clk) begin
    bit v;
    if (!rst && (!pin.valid || took)) begin
      v = 0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_q.size() > 0) begin
        if (!quiet && $urandom_range(0, 5) == 0) begin
          gap_left = $urandom_range(0, 2);
        end else begin
          cur = pending_q.pop_front();
          v = 1;
        end
      end
      pin.valid <= v;
      pin.seq_num <= cur.seq;
      pin.pkt_len <= cur.len;
      pin.pkt_handle <= cur.handle;
      pin.gop_start <= cur.gop;
      pin.now_time <= cur.now;
    end
  end

  // receiver: random stalls plus one long hold-off
  int stall_left;
  int hold_left;

  always @(negedge clk) begin
    if (rst) begin
      rout.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rout.ready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 0;
      hold_left = 400;
      rout.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rout.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 2);
      rout.ready <= 1'b0;
    end else begin
      rout.ready <= 1'b1;
    end
  end

  function automatic void check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    res_t e;
    if (!rst && rout.valid && rout.ready) begin
      if (expected_q.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        e = expected_q.pop_front();
        check_field("has_packet", e.has_packet, rout.has_packet);
        check_field("out_handle", e.handle, rout.out_handle);
        check_field("out_len", e.len, rout.out_len);
        check_field("out_gop_start", e.gop, rout.out_gop_start);
        check_field("step_status", e.status, rout.step_status);
        check_field("skipped_count", e.skipped, rout.skipped_count);
        check_field("last", e.last, rout.last);
      end
    end
  end

  int cycles;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  logic [31:0] clock_ms;
  logic [15:0] seq_cursor;

  function automatic void add_pkt(logic [15:0] seq, logic [10:0] len, logic [31:0] now);
    pkt_t p;
    p.seq = seq;
    p.len = len;
    p.handle = 16'($urandom_range(0, 16'hFFFF));
    p.gop = 1'($urandom_range(0, 1));
    p.now = now;
    pending_q.push_back(p);
  endfunction

  function automatic logic [10:0] rand_len();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 11'd0;
    if (r == 1) return 11'($urandom_range(MaxBytes + 1, 2047));
    if (r == 2) return 11'(MaxBytes);
    return 11'($urandom_range(1, MaxBytes));
  endfunction

  function automatic void tick_clock();
    if ($urandom_range(0, 9) == 0) clock_ms = clock_ms + $urandom_range(100, 5000);
    else clock_ms = clock_ms + $urandom_range(0, 30);
  endfunction

  // runs of consecutive numbers, shuffled and with holes, plus noise
  task automatic fill_random(int count);
    logic [15:0] run [$];
    int          k;
    int          a;
    int          b;
    logic [15:0] t;
    while (count > 0) begin
      if ($urandom_range(0, 99) < 80) begin
        k = $urandom_range(2, 10);
        run.delete();
        for (int i = 0; i < k; i++) run.push_back(16'(seq_cursor + i));
        for (int i = 0; i < k / 2; i++) begin
          a = $urandom_range(0, k - 1);
          b = $urandom_range(0, k - 1);
          t = run[a];
          run[a] = run[b];
          run[b] = t;
        end
        if ($urandom_range(0, 3) == 0) void'(run.pop_front());
        seq_cursor = 16'(seq_cursor + k);
        foreach (run[i]) begin
          tick_clock();
          add_pkt(run[i], rand_len(), clock_ms);
          count--;
        end
      end else begin
        tick_clock();
        case ($urandom_range(0, 3))
          0: add_pkt(16'(seq_cursor - $urandom_range(1, 40)), rand_len(), clock_ms);
          1: add_pkt(16'(seq_cursor + $urandom_range(20, 60)), rand_len(), clock_ms);
          2: add_pkt(16'($urandom_range(0, 16'hFFFF)), rand_len(), clock_ms);
          default: add_pkt(seq_cursor, 11'd0, clock_ms);
        endcase
        count--;
      end
    end
  endtask

  task automatic wait_idle();
    while (pending_q.size() > 0 || pin.valid || expected_q.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(rrb_pkg::cfg_reg_t idx, logic [31:0] val);
    @(negedge clk);
    cfgc.valid = 1'b1;
    cfgc.index = idx;
    cfgc.data = val;
    do @(posedge clk); while (!cfgc.ready);
    if (idx == rrb_pkg::CFG_GAP_TIMEOUT) gap_to = val;
    else fb_to = val;
    @(negedge clk);
    cfgc.valid = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    pin.valid = 1'b0;
    pin.seq_num = '0;
    pin.pkt_len = '0;
    pin.pkt_handle = '0;
    pin.gop_start = 1'b0;
    pin.now_time = '0;
    cfgc.valid = 1'b0;
    cfgc.index = rrb_pkg::CFG_GAP_TIMEOUT;
    cfgc.data = '0;
    gap_to = '0;
    fb_to = 32'd100;
    clear_stream();
    cur = '{default: '0};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // first packet anchors at time zero, then bad lengths and gap handling
    add_pkt(16'hFFFE, 11'd1, 32'd0);
    add_pkt(16'hFFFF, 11'd0, 32'd0);
    add_pkt(16'hFFFF, 11'd1501, 32'd0);
    add_pkt(16'hFFFF, 11'd2047, 32'd0);
    pending_q.push_back('{16'hFFFF, 11'd1500, 16'hFFFF, 1'b1, 32'd0});
    add_pkt(16'd1, 11'd40, 32'd0);
    add_pkt(16'd31, 11'd40, 32'd5);
    add_pkt(16'd1, 11'd41, 32'd6);
    add_pkt(16'd0, 11'd42, 32'd7);
    add_pkt(16'hFFF0, 11'd42, 32'd8);
    add_pkt(16'd2 + 16'h8000, 11'd42, 32'd9);
    add_pkt(16'd4, 11'd42, 32'd50);
    add_pkt(16'd3, 11'd42, 32'd200);
    add_pkt(16'd40, 11'd42, 32'hFFFF_FFF0);
    add_pkt(16'd42, 11'd42, 32'hFFFF_FFF8);
    add_pkt(16'd41, 11'd42, 32'h0000_0070);
    add_pkt(16'd80, 11'd42, 32'h0000_0080);
    pending_q.push_back('{16'd81, 11'd1, 16'h0000, 1'b0, 32'h0000_0081});
    wait_idle();

    clock_ms = 32'd1000;
    seq_cursor = 16'd82;
    write_reg(rrb_pkg::CFG_GAP_TIMEOUT, 32'd0);
    write_reg(rrb_pkg::CFG_FALLBACK_TIMEOUT, 32'd100);
    fill_random(80);
    wait_idle();

    write_reg(rrb_pkg::CFG_GAP_TIMEOUT, 32'd20);
    hold_req = 1;
    fill_random(80);
    wait_idle();

    write_reg(rrb_pkg::CFG_GAP_TIMEOUT, 32'd0);
    write_reg(rrb_pkg::CFG_FALLBACK_TIMEOUT, 32'd1);
    clock_ms = 32'hFFFF_F000;
    fill_random(80);
    wait_idle();

    write_reg(rrb_pkg::CFG_GAP_TIMEOUT, 32'hFFFF_FFFF);
    fill_random(80);
    wait_idle();

    quiet = 1;
    write_reg(rrb_pkg::CFG_GAP_TIMEOUT, 32'd1);
    write_reg(rrb_pkg::CFG_FALLBACK_TIMEOUT, 32'hFFFF_FFFF);
    fill_random(80);
    wait_idle();

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### files.f
design/rrb_pkg.sv
design/rrb_if.sv
design/rrb_ram.sv
design/rrb_front.sv
design/rrb_engine.sv
design/rtp_reorder_buffer_top.sv
design/rrb_checker.sv
tb/sv/rtp_reorder_buffer_top_test.sv
